// File: rtl/rbt_pkg.sv
`timescale 1ns / 1ps
// shared types and codes of the ranked bid table
package rbt_pkg;

	// command codes carried in tuser
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	// one command as it arrives on the input stream
	typedef struct packed {
		logic        cmd;
		logic [15:0] bid_value;
		logic [6:0]  bidder_id;
		logic [31:0] commit_time;
		logic [7:0]  bid_count;
		logic [6:0]  rank_index;
	} cmd_t;

	// one result as it leaves on the output stream
	typedef struct packed {
		logic [6:0]  insert_rank;
		logic        insert_refused;
		logic [7:0]  entries_held;
		logic        read_valid;
		logic [15:0] read_bid;
		logic [6:0]  read_bidder;
		logic [31:0] read_time;
		logic [7:0]  read_count;
	} res_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_PUT,
		ST_DONE
	} state_t;

endpackage

// File: rtl/ranked_bid_table_insert.sv
`timescale 1ns / 1ps
// top level of the ranked bid table: stream ports, command unpack, output register
//
// channel  direction  handshake          payload
// s_*      in         s_tvalid/s_tready  s_tuser = cmd, s_tdata = bid, bidder, time, count, rank
// m_*      out        m_tvalid/m_tready  m_tuser = refused, read_valid; m_tdata = result fields
//
// a read issues its memory read when the command transfers, then takes the registered read data
// into the result in ST_READ; a read at or past the fill level goes to ST_DONE with no memory access
// an insert reads the bottom entry when the command transfers; the scan then walks up from the bottom
// entry to the landing rank, one memory read and one shifted write per cycle; an insert into an empty
// table or a refused insert goes to ST_DONE with no scan
// arst_n clears the fill count and control; stored entries are not cleared
// a finished result waits in the output register while the next command is taken

module ranked_bid_table_insert #(
	parameter int MAX_ENTRIES = 128,
	parameter int BID_BITS    = 16,
	parameter int TIME_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // bid_value, bidder_id, commit_time, bid_count, rank_index
	input  logic        s_tuser,  // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // insert_rank, entries_held, read_bid, read_bidder,
	                              // read_time, read_count
	output logic [1:0]  m_tuser   // insert_refused, read_valid
);

	import rbt_pkg::*;

	cmd_t cmd_in;
	res_t res, res_q;
	logic res_valid, res_ready;
	logic m_tvalid_q;

	// command fields from the input transfer
	assign cmd_in.cmd         = s_tuser;
	assign cmd_in.bid_value   = s_tdata[15:0];
	assign cmd_in.bidder_id   = s_tdata[22:16];
	assign cmd_in.commit_time = s_tdata[54:23];
	assign cmd_in.bid_count   = s_tdata[62:55];
	assign cmd_in.rank_index  = s_tdata[69:63];

	rbt_seq #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.BID_BITS    (BID_BITS),
		.TIME_BITS   (TIME_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_tvalid),
		.cmd_ready (s_tready),
		.cmd_in    (cmd_in),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_out   (res)
	);

	// output register takes a result when empty or being drained
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

	// result fields onto the output transfer
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, res_q.read_count, res_q.read_time, res_q.read_bidder,
		res_q.read_bid, res_q.entries_held, res_q.insert_rank};
	assign m_tuser  = {res_q.read_valid, res_q.insert_refused};

`ifndef NO_ASSERTIONS
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

	a_no_load_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !res_ready)
		else $error("result register overwritten while stalled");

	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (!m_tuser[1] && (m_tdata[6:0] == 7'd0)))
		else $error("refused insert carries rank or read data");
`endif

endmodule

// File: rtl/rbt_mem.sv
`timescale 1ns / 1ps
// entry storage: one write port, one read port, registered read data
module rbt_mem #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 63
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, old data on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/rbt_seq.sv
`timescale 1ns / 1ps
// insert and read sequencer: scans the table from the bottom and shifts entries down
module rbt_seq #(
	parameter int MAX_ENTRIES = 128,
	parameter int BID_BITS    = 16,
	parameter int TIME_BITS   = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  rbt_pkg::cmd_t cmd_in,
	output logic          res_valid,
	input  logic          res_ready,
	output rbt_pkg::res_t res_out
);

	import rbt_pkg::*;

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int XW = (CW > 7) ? CW : 7;
	localparam int EW = BID_BITS + 7 + TIME_BITS + 8;
	localparam int BID_LO = 0;
	localparam int WHO_LO = BID_LO + BID_BITS;
	localparam int TIM_LO = WHO_LO + 7;
	localparam int CNT_LO = TIM_LO + TIME_BITS;

	state_t state_q, state_d;

	logic [CW-1:0] fill_q, fill_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [EW-1:0] new_q;
	res_t          res_q, res_d;
	logic          load_new;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;

	logic [EW-1:0]        in_entry;
	logic [BID_BITS-1:0]  new_bid, rd_bid;
	logic [TIME_BITS-1:0] new_time, rd_time;
	logic                 rd_ahead;
	logic [AW-1:0]        ptr_inc, ptr_dec, fill_last;
	logic [CW-1:0]        fill_inc;

	rbt_mem #(
		.DEPTH (MAX_ENTRIES),
		.WIDTH (EW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// incoming entry packed as stored
	assign in_entry = {cmd_in.bid_count, TIME_BITS'(cmd_in.commit_time),
		cmd_in.bidder_id, BID_BITS'(cmd_in.bid_value)};

	// held entry stays ahead on higher bid, or equal bid and not later time
	assign new_bid  = new_q[BID_LO +: BID_BITS];
	assign new_time = new_q[TIM_LO +: TIME_BITS];
	assign rd_bid   = rdata[BID_LO +: BID_BITS];
	assign rd_time  = rdata[TIM_LO +: TIME_BITS];
	assign rd_ahead = (rd_bid > new_bid) || ((rd_bid == new_bid) && (rd_time <= new_time));

	assign ptr_inc   = ptr_q + AW'(1);
	assign ptr_dec   = ptr_q - AW'(1);
	assign fill_last = AW'(fill_q - CW'(1));
	assign fill_inc  = fill_q + CW'(1);

	assign cmd_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res_out   = res_q;

	// next state, memory port control and result
	always_comb begin
		state_d  = state_q;
		fill_d   = fill_q;
		ptr_d    = ptr_q;
		res_d    = res_q;
		load_new = 1'b0;
		we       = 1'b0;
		waddr    = '0;
		wdata    = new_q;
		re       = 1'b0;
		raddr    = ptr_dec;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					res_d = '0;
					res_d.entries_held = 8'(fill_q);
					if (cmd_in.cmd == CMD_INSERT) begin
						load_new = 1'b1;
						if (fill_q == CW'(MAX_ENTRIES)) begin
							res_d.insert_refused = 1'b1;
							state_d = ST_DONE;
						end else if (fill_q == '0) begin
							we     = 1'b1;
							waddr  = '0;
							wdata  = in_entry;
							fill_d = fill_inc;
							res_d.entries_held = 8'(fill_inc);
							state_d = ST_DONE;
						end else begin
							re      = 1'b1;
							raddr   = fill_last;
							ptr_d   = fill_last;
							state_d = ST_SCAN;
						end
					end else begin
						if (XW'(cmd_in.rank_index) < XW'(fill_q)) begin
							re    = 1'b1;
							raddr = AW'(cmd_in.rank_index);
							res_d.read_valid = 1'b1;
							state_d = ST_READ;
						end else begin
							state_d = ST_DONE;
						end
					end
				end
			end
			ST_READ: begin
				res_d.read_bid    = 16'(rd_bid);
				res_d.read_bidder = rdata[WHO_LO +: 7];
				res_d.read_time   = 32'(rd_time);
				res_d.read_count  = rdata[CNT_LO +: 8];
				state_d = ST_DONE;
			end
			ST_SCAN: begin
				we    = 1'b1;
				waddr = ptr_inc;
				if (rd_ahead) begin
					wdata  = new_q;
					fill_d = fill_inc;
					res_d.insert_rank  = 7'(ptr_inc);
					res_d.entries_held = 8'(fill_inc);
					state_d = ST_DONE;
				end else begin
					wdata = rdata;
					if (ptr_q == '0) begin
						state_d = ST_PUT;
					end else begin
						re    = 1'b1;
						raddr = ptr_dec;
						ptr_d = ptr_dec;
					end
				end
			end
			ST_PUT: begin
				we     = 1'b1;
				waddr  = '0;
				wdata  = new_q;
				fill_d = fill_inc;
				res_d.insert_rank  = '0;
				res_d.entries_held = 8'(fill_inc);
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		res_q <= res_d;
		if (load_new) begin
			new_q <= in_entry;
		end
	end

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(MAX_ENTRIES))
		else $error("fill level beyond table size");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (CW'(ptr_q) < fill_q))
		else $error("scan pointer outside held entries");

	a_put_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUT) |=> (fill_q == $past(fill_inc)))
		else $error("insert at top did not grow the table");

	a_read_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> ($past(state_q) == ST_IDLE))
		else $error("read data stage not entered from idle");
`endif

endmodule

// File: verif/ranked_bid_table_checker.sv
`timescale 1ns / 1ps
// checker for the ranked bid table: predicts each result and compares it on the output stream
module ranked_bid_table_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,  // bid_value, bidder_id, commit_time, bid_count, rank_index
	input  logic        s_tuser,  // cmd
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [79:0] m_tdata,  // insert_rank, entries_held, read_bid, read_bidder,
	                              // read_time, read_count
	input  logic [1:0]  m_tuser,  // insert_refused, read_valid
	output int          failures,
	output int          pending
);
	import rbt_pkg::*;

	localparam int TABLE_DEPTH = 128;

	// shadow copy of the ranking table
	logic [15:0] shadow_bid    [TABLE_DEPTH];
	logic [6:0]  shadow_bidder [TABLE_DEPTH];
	logic [31:0] shadow_time   [TABLE_DEPTH];
	logic [7:0]  shadow_count  [TABLE_DEPTH];
	int          shadow_fill = 0;

	res_t awaited_results[$];
	int   mismatch_count = 0;

	// apply one command to the shadow table and return the result it must give
	function automatic res_t rank_table_step(cmd_t c);
		res_t r;
		int   slot;
		int   i;
		r = '0;
		if (c.cmd == CMD_INSERT) begin
			if (shadow_fill >= TABLE_DEPTH) begin
				r.insert_refused = 1'b1;
			end else begin
				// entries with a higher bid, or an equal bid committed no later, stay ahead
				slot = 0;
				for (i = 0; i < shadow_fill; i++) begin
					if (shadow_bid[i] > c.bid_value ||
					    (shadow_bid[i] == c.bid_value && shadow_time[i] <= c.commit_time))
						slot++;
				end
				for (i = shadow_fill; i > slot; i--) begin
					shadow_bid[i]    = shadow_bid[i - 1];
					shadow_bidder[i] = shadow_bidder[i - 1];
					shadow_time[i]   = shadow_time[i - 1];
					shadow_count[i]  = shadow_count[i - 1];
				end
				shadow_bid[slot]    = c.bid_value;
				shadow_bidder[slot] = c.bidder_id;
				shadow_time[slot]   = c.commit_time;
				shadow_count[slot]  = c.bid_count;
				shadow_fill++;
				r.insert_rank = slot[6:0];
			end
		end else if (int'(c.rank_index) < shadow_fill) begin
			r.read_valid  = 1'b1;
			r.read_bid    = shadow_bid[c.rank_index];
			r.read_bidder = shadow_bidder[c.rank_index];
			r.read_time   = shadow_time[c.rank_index];
			r.read_count  = shadow_count[c.rank_index];
		end
		r.entries_held = shadow_fill[7:0];
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// compare each result transfer, then predict from each command transfer
	always @(posedge clk or negedge arst_n) begin : watch
		res_t got;
		res_t want;
		cmd_t c;
		if (!arst_n) begin
			shadow_fill = 0;
			awaited_results.delete();
			pending  <= 0;
			failures <= mismatch_count;
		end else begin
			if (m_tvalid && m_tready) begin
				got.insert_rank    = m_tdata[6:0];
				got.entries_held   = m_tdata[14:7];
				got.read_bid       = m_tdata[30:15];
				got.read_bidder    = m_tdata[37:31];
				got.read_time      = m_tdata[69:38];
				got.read_count     = m_tdata[77:70];
				got.insert_refused = m_tuser[0];
				got.read_valid     = m_tuser[1];
				if (awaited_results.size() == 0) begin
					$error("result transfer with no command waiting for it");
					mismatch_count++;
				end else begin
					want = awaited_results.pop_front();
					check_field("insert_rank", 32'(want.insert_rank), 32'(got.insert_rank));
					check_field("insert_refused", 32'(want.insert_refused),
						32'(got.insert_refused));
					check_field("entries_held", 32'(want.entries_held), 32'(got.entries_held));
					check_field("read_valid", 32'(want.read_valid), 32'(got.read_valid));
					check_field("read_bid", 32'(want.read_bid), 32'(got.read_bid));
					check_field("read_bidder", 32'(want.read_bidder), 32'(got.read_bidder));
					check_field("read_time", want.read_time, got.read_time);
					check_field("read_count", 32'(want.read_count), 32'(got.read_count));
				end
			end
			if (s_tvalid && s_tready) begin
				c.cmd         = s_tuser;
				c.bid_value   = s_tdata[15:0];
				c.bidder_id   = s_tdata[22:16];
				c.commit_time = s_tdata[54:23];
				c.bid_count   = s_tdata[62:55];
				c.rank_index  = s_tdata[69:63];
				awaited_results.push_back(rank_table_step(c));
			end
			pending  <= awaited_results.size();
			failures <= mismatch_count;
		end
	end

endmodule

// File: verif/ranked_bid_table_insert_tb.sv
`timescale 1ns / 1ps
// testbench top for the ranked bid table: clock, reset, command stimulus and verdict
module ranked_bid_table_insert_tb;
	import rbt_pkg::*;

	localparam int TABLE_DEPTH = 128;
	localparam int DRAIN_CYCLES = 160;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic [1:0]  m_tuser;
	int          failures;
	int          pending;

	logic quiet_tail;
	int   stall_left;
	int   table_fill;

	ranked_bid_table_insert dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	ranked_bid_table_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.failures (failures),
		.pending  (pending)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// result side backpressure: random stall bursts, none in the tail
	always @(negedge clk) begin
		if (quiet_tail) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 5);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// hold one command until its transfer
	task automatic send_cmd(logic c, logic [15:0] bid, logic [6:0] who, logic [31:0] stamp,
	                        logic [7:0] n, logic [6:0] rank);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= {2'b00, rank, n, stamp, who, bid};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (c == CMD_INSERT && table_fill < TABLE_DEPTH)
			table_fill++;
	endtask

	task automatic sender_gap(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
	endtask

	// hold off until every result is back
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
	endtask

	// random command: mostly inserts with crowded bids and times, reads mostly at ranks up to the fill level
	task automatic send_random_cmd();
		logic [15:0] bid;
		logic [31:0] stamp;
		logic [6:0]  rank;
		int          pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			bid = 16'd1000 + 16'($urandom_range(0, 3));
		else if (pick == 4)
			bid = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		else
			bid = 16'($urandom());
		stamp = ($urandom_range(0, 9) < 4) ? 32'($urandom_range(0, 3)) : $urandom();
		if ($urandom_range(0, 9) < 8)
			rank = 7'($urandom_range(0, table_fill > 127 ? 127 : table_fill));
		else
			rank = 7'($urandom_range(0, 127));
		send_cmd(($urandom_range(0, 99) < 62) ? CMD_INSERT : CMD_READ, bid,
		         7'($urandom_range(0, 127)), stamp, 8'($urandom_range(0, 255)), rank);
	endtask

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tuser    = CMD_INSERT;
		s_tdata    = '0;
		quiet_tail = 1'b0;
		table_fill = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// reads of an empty table
		send_cmd(CMD_READ, 16'h0000, 7'd0, 32'h0, 8'h00, 7'd0);
		send_cmd(CMD_READ, 16'hFFFF, 7'd127, 32'hFFFF_FFFF, 8'hFF, 7'd127);
		// equal bids: earlier commit ranks first, exact tie keeps the held entry ahead
		send_cmd(CMD_INSERT, 16'd1000, 7'd1, 32'd500, 8'd10, 7'd0);
		send_cmd(CMD_INSERT, 16'd1000, 7'd2, 32'd500, 8'd20, 7'd0);
		send_cmd(CMD_INSERT, 16'd1000, 7'd3, 32'd499, 8'd30, 7'd0);
		send_cmd(CMD_INSERT, 16'd1000, 7'd4, 32'd501, 8'd40, 7'd0);
		// field extremes
		send_cmd(CMD_INSERT, 16'hFFFF, 7'd127, 32'hFFFF_FFFF, 8'hFF, 7'd127);
		send_cmd(CMD_INSERT, 16'h0000, 7'd0, 32'h0, 8'h00, 7'd0);
		send_cmd(CMD_INSERT, 16'hFFFF, 7'd5, 32'h0, 8'h01, 7'd0);
		send_cmd(CMD_INSERT, 16'h0000, 7'd6, 32'hFFFF_FFFF, 8'h80, 7'd0);
		// walk the ranks, then the first rank past the fill level and the last rank
		for (int r = 0; r < 8; r++)
			send_cmd(CMD_READ, 16'h0, 7'd0, 32'h0, 8'h0, 7'(r));
		send_cmd(CMD_READ, 16'h0, 7'd0, 32'h0, 8'h0, 7'd8);
		send_cmd(CMD_READ, 16'h0, 7'd0, 32'h0, 8'h0, 7'd127);
		wait_drained();

		// random commands with sender gaps; the table fills and later inserts are refused
		for (int k = 0; k < 430; k++) begin
			if (k == 150)
				wait_drained();
			if (k == 350)
				quiet_tail = 1'b1;
			send_random_cmd();
			if (!quiet_tail && $urandom_range(0, 3) == 0)
				sender_gap($urandom_range(1, 6));
		end
		// reads at a full table, top and bottom ranks, then a refused insert
		send_cmd(CMD_READ, 16'h0, 7'd0, 32'h0, 8'h0, 7'd0);
		send_cmd(CMD_READ, 16'h0, 7'd0, 32'h0, 8'h0, 7'd127);
		send_cmd(CMD_INSERT, 16'hFFFF, 7'd9, 32'h0, 8'h09, 7'd0);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/rbt_pkg.sv
rtl/rbt_mem.sv
rtl/rbt_seq.sv
rtl/ranked_bid_table_insert.sv
verif/ranked_bid_table_checker.sv
verif/ranked_bid_table_insert_tb.sv
